[rtl/core/srfl_pkg.sv]
// shared types, constants and helpers for the sorted range floor lookup
package srfl_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 64;
  localparam int OUT_IDX_W   = 12;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_DUP      = 3'd2,
    ST_ORDER    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_STEP
  } srch_state_t;

  typedef struct packed {
    func_t             func;
    logic [ADDR_W-1:0] entry_addr;
    logic [ADDR_W-1:0] query_ip;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [OUT_IDX_W-1:0] entry_index;
  } out_item_t;

  typedef struct packed {
    logic              go;
    logic [ADDR_W-1:0] query;
    logic [IDX_W-1:0]  hi;
  } srch_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             found;
    logic [IDX_W-1:0] index;
  } srch_rsp_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  function automatic logic [OUT_IDX_W-1:0] idx_out(input logic [IDX_W-1:0] i);
    logic [IDX_W+OUT_IDX_W-1:0] w;
    w = {{OUT_IDX_W{1'b0}}, i};
    return w[OUT_IDX_W-1:0];
  endfunction

endpackage

[rtl/core/srfl_ram.sv]
// generic single write port ram with registered read
module srfl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/srfl_search.sv]
// binary search sequencer issuing one table read per step
module srfl_search (
  input  logic                      clk,
  input  logic                      rst,
  input  srfl_pkg::srch_req_t       req,
  input  logic [srfl_pkg::ADDR_W-1:0] last_addr,
  input  logic [srfl_pkg::ADDR_W-1:0] rdata,
  output srfl_pkg::ram_rd_t         rd,
  output srfl_pkg::srch_rsp_t       rsp
);
  import srfl_pkg::*;

  srch_state_t       state, state_next;
  logic [ADDR_W-1:0] query, query_next;
  logic [IDX_W-1:0]  lo, lo_next;
  logic [IDX_W-1:0]  hi, hi_next;
  logic [IDX_W-1:0]  mid, mid_next;
  logic [IDX_W-1:0]  step_lo, step_hi;
  logic [IDX_W:0]    mid_sum;
  logic              le;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    query <= query_next;
    lo    <= lo_next;
    hi    <= hi_next;
    mid   <= mid_next;
  end

  always_comb begin
    state_next = state;
    query_next = query;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    rd         = '0;
    rsp        = '0;
    rsp.busy   = (state != S_IDLE);
    le         = (rdata <= query);
    step_lo    = le ? mid : lo;
    step_hi    = le ? hi : mid;
    mid_sum    = {1'b0, lo} + {1'b0, hi};
    unique case (state)
      S_IDLE: begin
        if (req.go) begin
          query_next = req.query;
          lo_next    = '0;
          hi_next    = req.hi;
          rd.en      = 1'b1;
          rd.addr    = '0;
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        if (query < rdata) begin
          rsp.done   = 1'b1;
          rsp.found  = 1'b0;
          state_next = S_IDLE;
        end else if (query >= last_addr) begin
          rsp.done   = 1'b1;
          rsp.found  = 1'b1;
          rsp.index  = hi;
          state_next = S_IDLE;
        end else if ((hi - lo) > IDX_W'(1)) begin
          mid_next   = mid_sum[IDX_W:1];
          rd.en      = 1'b1;
          rd.addr    = mid_sum[IDX_W:1];
          state_next = S_STEP;
        end else begin
          rsp.done   = 1'b1;
          rsp.found  = 1'b1;
          rsp.index  = lo;
          state_next = S_IDLE;
        end
      end
      S_STEP: begin
        lo_next = step_lo;
        hi_next = step_hi;
        mid_sum = {1'b0, step_lo} + {1'b0, step_hi};
        if ((step_hi - step_lo) > IDX_W'(1)) begin
          mid_next = mid_sum[IDX_W:1];
          rd.en    = 1'b1;
          rd.addr  = mid_sum[IDX_W:1];
        end else begin
          rsp.done   = 1'b1;
          rsp.found  = 1'b1;
          rsp.index  = step_lo;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_step_bracket: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (lo < mid && mid < hi))
    else $error("search bracket collapsed");

  a_step_reads: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && !rsp.done) |-> (rd.en && state_next == S_STEP))
    else $error("search step without read");

endmodule

[rtl/core/sorted_range_floor_lookup.sv]
// top level: command decode, entry count, last entry and result register
//
// One command channel in, one result channel out. A command item is taken on
// a rising edge with start high and busy low; func selects clear, append or
// lookup. Every item gives exactly one result, shown on result for a single
// cycle with done high; the receiver cannot hold it off.
// Clear, append and the unused code answer one cycle after acceptance, and
// busy stays low, so such items may follow every cycle.
// A lookup on an empty table is answered the same way. Otherwise it
// reads the first entry, checks the last entry (held in a register), then
// halves the bracket once per ram read until the result is settled.
// The single ram read port limits the search to one read per step.
// busy is high from the cycle after a lookup on a non-empty table is taken until its result shows.
// Reset empties the table at once (entry count to zero); ram contents are
// left as they are and never read before being written. No clearing pass.
module sorted_range_floor_lookup (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  srfl_pkg::in_item_t  cmd,
  output logic                busy,
  output logic                done,
  output srfl_pkg::out_item_t result
);
  import srfl_pkg::*;

  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [ADDR_W-1:0] last_addr, last_addr_next;
  logic              done_next;
  out_item_t         result_next;
  logic              accept;
  logic              we;
  logic [ADDR_W-1:0] rdata;
  srch_req_t         req;
  srch_rsp_t         rsp;
  ram_rd_t           rd;

  srfl_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(entry_count[IDX_W-1:0]),
    .wdata(cmd.entry_addr),
    .re   (rd.en),
    .raddr(rd.addr),
    .rdata(rdata)
  );

  srfl_search u_search (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .last_addr(last_addr),
    .rdata    (rdata),
    .rd       (rd),
    .rsp      (rsp)
  );

  assign busy   = rsp.busy;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      done        <= done_next;
    end
    last_addr <= last_addr_next;
    result    <= result_next;
  end

  always_comb begin
    entry_count_next = entry_count;
    last_addr_next   = last_addr;
    done_next        = 1'b0;
    result_next      = '{status: ST_OK, entry_index: '0};
    we               = 1'b0;
    req              = '0;
    req.query        = cmd.query_ip;
    req.hi           = IDX_W'(entry_count - CNT_W'(1));
    if (accept) begin
      unique case (cmd.func)
        FUNC_CLEAR: begin
          entry_count_next = '0;
          done_next        = 1'b1;
        end
        FUNC_APPEND: begin
          done_next = 1'b1;
          if (entry_count != '0 && cmd.entry_addr == last_addr) begin
            result_next.status = ST_DUP;
          end else if (entry_count != '0 && cmd.entry_addr < last_addr) begin
            result_next.status = ST_ORDER;
          end else if (entry_count == CNT_W'(TABLE_DEPTH)) begin
            result_next.status = ST_FULL;
          end else begin
            we                      = 1'b1;
            result_next.entry_index = idx_out(entry_count[IDX_W-1:0]);
            entry_count_next        = entry_count + CNT_W'(1);
            last_addr_next          = cmd.entry_addr;
          end
        end
        FUNC_LOOKUP: begin
          if (entry_count == '0) begin
            done_next          = 1'b1;
            result_next.status = ST_NOTFOUND;
          end else begin
            req.go = 1'b1;
          end
        end
        default: begin
          done_next = 1'b1;
        end
      endcase
    end
    if (rsp.done) begin
      done_next = 1'b1;
      if (rsp.found) begin
        result_next.status      = ST_OK;
        result_next.entry_index = idx_out(rsp.index);
      end else begin
        result_next.status = ST_NOTFOUND;
      end
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    !(done && busy))
    else $error("result shown while search still running");

  a_item_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted item neither answered nor in search");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

endmodule

[tb/sv/tb_sorted_range_floor_lookup.sv]
// testbench for the sorted range floor lookup: directed rows, random table sessions, full fill
module tb_sorted_range_floor_lookup;
  import srfl_pkg::*;

  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

  typedef struct {
    func_t             func;
    logic [ADDR_W-1:0] entry_addr;
    logic [ADDR_W-1:0] query_ip;
    bit                typed;
    status_t           status;
    int                index;
  } dir_row_t;

  logic      clk;
  logic      rst;
  logic      start;
  in_item_t  cmd;
  logic      busy;
  logic      done;
  out_item_t result;

  logic [ADDR_W-1:0] shadow_addrs [TABLE_DEPTH];
  int                shadow_count;
  out_item_t         awaited_results [$];
  out_item_t         oldest;
  dir_row_t          dir_rows [$];
  int                err_count;
  int                n_items;
  bit                steady;

  sorted_range_floor_lookup dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb_sorted_range_floor_lookup: done, errors");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // shadow model of each command; lookup is a floor search by linear scan from the top of the filled entries
  function automatic out_item_t apply_command(input in_item_t c);
    out_item_t r;
    int        i;
    r.status      = ST_OK;
    r.entry_index = '0;
    case (c.func)
      FUNC_CLEAR: shadow_count = 0;
      FUNC_APPEND: begin
        if (shadow_count > 0 && c.entry_addr == shadow_addrs[shadow_count-1]) begin
          r.status = ST_DUP;
        end else if (shadow_count > 0 && c.entry_addr < shadow_addrs[shadow_count-1]) begin
          r.status = ST_ORDER;
        end else if (shadow_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_addrs[shadow_count] = c.entry_addr;
          r.entry_index              = OUT_IDX_W'(shadow_count);
          shadow_count++;
        end
      end
      FUNC_LOOKUP: begin
        r.status = ST_NOTFOUND;
        i = shadow_count - 1;
        while (i >= 0 && r.status == ST_NOTFOUND) begin
          if (shadow_addrs[i] <= c.query_ip) begin
            r.status      = ST_OK;
            r.entry_index = OUT_IDX_W'(i);
          end
          i--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_query();
    int                r;
    int                i;
    logic [ADDR_W-1:0] top;
    logic [ADDR_W-1:0] step;
    r = $urandom_range(99);
    if (shadow_count == 0) return rand64() >> $urandom_range(0, 63);
    top = shadow_addrs[shadow_count-1];
    if (r < 10) return rand64();
    if (r < 20) return (shadow_addrs[0] == 0) ? '0 : rand64() % shadow_addrs[0];
    i = $urandom_range(shadow_count - 1);
    if (r < 35) return shadow_addrs[i];
    if (r < 75 && i < shadow_count - 1)
      return shadow_addrs[i] + rand64() % (shadow_addrs[i+1] - shadow_addrs[i]);
    if (r < 92) begin
      step = rand64() >> $urandom_range(1, 63);
      return (top + step < top) ? ALL_ONES : top + step;
    end
    return ALL_ONES;
  endfunction

  task automatic note_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic issue(input in_item_t c, input bit typed, input out_item_t known);
    out_item_t         exp;
    logic [159:0]      noise;
    int                gap;
    if (!steady && $urandom_range(99) < 22) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
        start <= 1'b0;
        cmd   <= noise[$bits(in_item_t)-1:0];
      end
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    exp = apply_command(c);
    if (typed) exp = known;
    awaited_results.push_back(exp);
    if (c.func != FUNC_RSVD) n_items++;
  endtask

  task automatic send(input func_t f, input logic [ADDR_W-1:0] ea, input logic [ADDR_W-1:0] q);
    in_item_t  c;
    out_item_t none;
    c.func       = f;
    c.entry_addr = ea;
    c.query_ip   = q;
    none         = '0;
    issue(c, 1'b0, none);
  endtask

  task automatic row(input func_t f, input logic [ADDR_W-1:0] ea, input logic [ADDR_W-1:0] q,
                     input bit typed, input status_t st, input int idx);
    dir_row_t d;
    d.func       = f;
    d.entry_addr = ea;
    d.query_ip   = q;
    d.typed      = typed;
    d.status     = st;
    d.index      = idx;
    dir_rows.push_back(d);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("result with no item outstanding");
      end else begin
        oldest = awaited_results.pop_front();
        if (result.status !== oldest.status)
          note_mismatch($sformatf("status got %0d want %0d", result.status, oldest.status));
        if (result.entry_index !== oldest.entry_index)
          note_mismatch($sformatf("entry_index got %0d want %0d",
                                  result.entry_index, oldest.entry_index));
      end
    end
  end

  initial begin
    in_item_t          c;
    out_item_t         known;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] stride;
    int                n;
    int                sh;
    int                r;
    int                guard;
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = '0;
    shadow_count = 0;
    err_count    = 0;
    n_items      = 0;
    steady       = 1'b0;

    //  func         entry_addr            query_ip               typed  status       index
    row(FUNC_LOOKUP, '0,                   '0,                    1'b1,  ST_NOTFOUND, 0);
    row(FUNC_LOOKUP, '0,                   ALL_ONES,              1'b1,  ST_NOTFOUND, 0);
    row(FUNC_RSVD,   ALL_ONES,             ALL_ONES,              1'b1,  ST_OK,       0);
    row(FUNC_APPEND, '0,                   '0,                    1'b1,  ST_OK,       0);
    row(FUNC_APPEND, '0,                   ALL_ONES,              1'b1,  ST_DUP,      0);
    row(FUNC_LOOKUP, ALL_ONES,             '0,                    1'b1,  ST_OK,       0);
    row(FUNC_APPEND, 64'h10,               '0,                    1'b1,  ST_OK,       1);
    row(FUNC_APPEND, 64'h8,                '0,                    1'b1,  ST_ORDER,    0);
    row(FUNC_APPEND, 64'h10,               '0,                    1'b1,  ST_DUP,      0);
    row(FUNC_LOOKUP, '0,                   64'hf,                 1'b0,  ST_OK,       0);
    row(FUNC_LOOKUP, '0,                   64'h10,                1'b0,  ST_OK,       0);
    row(FUNC_LOOKUP, '0,                   ALL_ONES,              1'b1,  ST_OK,       1);
    row(FUNC_APPEND, ALL_ONES - 1,         '0,                    1'b0,  ST_OK,       0);
    row(FUNC_APPEND, ALL_ONES,             '0,                    1'b0,  ST_OK,       0);
    row(FUNC_APPEND, ALL_ONES,             '0,                    1'b1,  ST_DUP,      0);
    row(FUNC_APPEND, 64'h5,                '0,                    1'b1,  ST_ORDER,    0);
    row(FUNC_LOOKUP, '0,                   64'h8000000000000000,  1'b0,  ST_OK,       0);
    row(FUNC_LOOKUP, '0,                   ALL_ONES - 1,          1'b0,  ST_OK,       0);
    row(FUNC_CLEAR,  ALL_ONES,             ALL_ONES,              1'b1,  ST_OK,       0);
    row(FUNC_LOOKUP, '0,                   64'h10,                1'b1,  ST_NOTFOUND, 0);
    row(FUNC_APPEND, ALL_ONES,             '0,                    1'b1,  ST_OK,       0);
    row(FUNC_LOOKUP, '0,                   ALL_ONES - 1,          1'b1,  ST_NOTFOUND, 0);
    row(FUNC_LOOKUP, '0,                   ALL_ONES,              1'b1,  ST_OK,       0);
    row(FUNC_RSVD,   64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,  1'b1,  ST_OK,       0);
    row(FUNC_CLEAR,  '0,                   '0,                    1'b1,  ST_OK,       0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      c.func             = dir_rows[k].func;
      c.entry_addr       = dir_rows[k].entry_addr;
      c.query_ip         = dir_rows[k].query_ip;
      known.status       = dir_rows[k].status;
      known.entry_index  = OUT_IDX_W'(dir_rows[k].index);
      issue(c, dir_rows[k].typed, known);
    end

    // random table sessions: mostly ascending fills and lookups, some noise
    n_items = 0;
    while (n_items < 1700) begin
      steady = (n_items >= 600 && n_items < 900);
      if ($urandom_range(5) != 0) send(FUNC_CLEAR, rand64(), rand64());
      n  = ($urandom_range(7) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
      sh = $urandom_range(8, 63);
      a  = rand64() >> $urandom_range(0, 63);
      if (shadow_count > 0 && a <= shadow_addrs[shadow_count-1])
        a = shadow_addrs[shadow_count-1] + 1;
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(99);
        if (r < 6 && shadow_count > 0) begin
          send(FUNC_APPEND, shadow_addrs[shadow_count-1], rand64());
        end else if (r < 11 && shadow_count > 0 && shadow_addrs[shadow_count-1] != 0) begin
          send(FUNC_APPEND, rand64() % shadow_addrs[shadow_count-1], rand64());
        end else if (r < 13) begin
          c.func       = func_t'($urandom_range(1, 3));
          c.entry_addr = rand64();
          c.query_ip   = rand64();
          issue(c, 1'b0, known);
        end else begin
          send(FUNC_APPEND, a, rand64());
          stride = 1 + (rand64() >> sh);
          if (a + stride < a) k = n;
          a = a + stride;
        end
        if ($urandom_range(99) < 30) send(FUNC_LOOKUP, rand64(), pick_query());
      end
      repeat ($urandom_range(5, 30)) send(FUNC_LOOKUP, rand64(), pick_query());
    end
    steady = 1'b0;

    // fill to the full depth, then the full and overflow cases
    send(FUNC_CLEAR, '0, '0);
    a = rand64() >> 30;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      send(FUNC_APPEND, a, rand64());
      a = a + 1 + ($urandom >> $urandom_range(0, 31));
      if ($urandom_range(99) < 3) send(FUNC_LOOKUP, rand64(), pick_query());
    end
    send(FUNC_APPEND, shadow_addrs[TABLE_DEPTH-1], '0);
    send(FUNC_APPEND, shadow_addrs[TABLE_DEPTH-1] + 1, '0);
    send(FUNC_APPEND, '0, '0);
    send(FUNC_APPEND, ALL_ONES, '0);
    repeat (60) send(FUNC_LOOKUP, rand64(), pick_query());
    send(FUNC_LOOKUP, '0, ALL_ONES);
    send(FUNC_LOOKUP, '0, shadow_addrs[0]);
    send(FUNC_CLEAR, '0, '0);
    send(FUNC_LOOKUP, '0, ALL_ONES);

    @(negedge clk);
    start <= 1'b0;
    guard = 0;
    while (awaited_results.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (err_count == 0) begin
      $display("tb_sorted_range_floor_lookup: done, clean");
    end else begin
      $display("tb_sorted_range_floor_lookup: done, errors");
    end
    $finish;
  end

endmodule

[sorted_range_floor_lookup.f]
rtl/core/srfl_pkg.sv
rtl/core/srfl_ram.sv
rtl/core/srfl_search.sv
rtl/core/sorted_range_floor_lookup.sv
tb/sv/tb_sorted_range_floor_lookup.sv
